[design/csr_pkg.sv]
// Shared types and constants for the canvas shape rasterizer.
package csr_pkg;

    localparam int CANVAS_COLS = 40;
    localparam int CANVAS_ROWS = 20;
    localparam int NUM_PIX     = CANVAS_COLS * CANVAS_ROWS;

    localparam int X_W    = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam int Y_W    = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int ADDR_W = (NUM_PIX > 1) ? $clog2(NUM_PIX) : 1;

    localparam int FIELD_W = 11;  // width of the coordinate and size fields
    localparam int CALC_W  = 13;  // signed coordinate differences and bounds
    localparam int DSQ_W   = 22;  // one squared difference, below 2**22
    localparam int SQ_W    = 23;  // squared distance and radius thresholds

    localparam logic [1:0] SHADE_BLACK = 2'd0;
    localparam logic [1:0] SHADE_GRAY  = 2'd1;
    localparam logic [1:0] SHADE_WHITE = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_RECT   = 2'd1,
        CMD_CIRCLE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT,
        S_INIT_DRAIN,
        S_IDLE,
        S_SETUP,
        S_SWEEP,
        S_DRAIN,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic rd_issue;
        logic rd_capture;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_pixel;
        logic pipe_busy;
    } t_dp_stat;

endpackage

[design/canvas_shape_rasterizer_unit.sv]
// Top level of the canvas shape rasterizer: controller plus datapath.
//
// A 40 x 20 canvas of two-bit shades (0 black, 1 gray, 2 white) held in an
// on-chip frame store. Drive start with a command while busy is low; the
// command and its operands transfer at that clock edge. Every command yields
// exactly one result: o_done pulses high for a single cycle with o_shade and
// o_off_canvas valid in that same cycle, and there is no way to stall it, so
// the receiver must capture it then. Outside the o_done cycle both result
// ports read zero. Clear, rectangle and circle sweep the whole canvas
// one pixel per cycle through the frame store's single write port, then
// drain the pixel pipe and raise o_done; the block is back to idle the
// cycle after o_done. A pixel read issues a registered memory read, then
// captures the data and raises o_done. After reset the block runs a
// clearing pass that writes black to all 800 pixels, one per cycle, and
// holds busy high until it ends; no command transfers until then and that
// pass gives no result.
//
// Commands:
//   clear     - every pixel black.
//   rectangle - columns [x, x+w), rows [y, y+h), clipped to the canvas; the
//               ring of the unclipped rectangle is white, the inside gray.
//               Width or height of zero or less draws nothing.
//   circle    - squared distance d from (x, y), radius r: gray when
//               d <= r*r-r, white when r*r-r < d <= r*r+r, else untouched.
//               Radius zero whitens only the centre; negative draws nothing.
//   read      - shade of pixel (x, y); off the canvas gives shade 0 with
//               o_off_canvas set. Other commands report 0 on both ports.
//
// Circle pixels go through a two-deep pipe: squares of the offsets are
// registered, then summed and compared against thresholds computed once
// per command from r.
module canvas_shape_rasterizer_unit
    import csr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      o_done,
    input  logic [1:0]                i_command,
    input  logic signed [FIELD_W-1:0] i_pos_x,
    input  logic signed [FIELD_W-1:0] i_pos_y,
    input  logic signed [FIELD_W-1:0] i_size_a,
    input  logic signed [FIELD_W-1:0] i_size_b,
    output logic [1:0]                o_shade,
    output logic                      o_off_canvas
);

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic [1:0] dp_shade;
    logic       dp_off;

    csr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_dp      (dp_cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    csr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp         (dp_cmd),
        .i_command    (i_command),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_size_a     (i_size_a),
        .i_size_b     (i_size_b),
        .o_stat       (dp_stat),
        .o_shade      (dp_shade),
        .o_off_canvas (dp_off)
    );

    // results read zero except in the strobe cycle
    assign o_shade      = o_done ? dp_shade : SHADE_BLACK;
    assign o_off_canvas = o_done && dp_off;

endmodule

[design/csr_datapath.sv]
// Datapath: command registers, pixel sweep, shape tests and the frame store.
module csr_datapath
    import csr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_dp,
    input  logic [1:0]                i_command,
    input  logic signed [FIELD_W-1:0] i_pos_x,
    input  logic signed [FIELD_W-1:0] i_pos_y,
    input  logic signed [FIELD_W-1:0] i_size_a,
    input  logic signed [FIELD_W-1:0] i_size_b,
    output t_dp_stat                  o_stat,
    output logic [1:0]                o_shade,
    output logic                      o_off_canvas
);

    logic [1:0] r_mem [NUM_PIX];

    t_cmd                      r_cmd;
    logic signed [FIELD_W-1:0] r_px, r_py, r_sa, r_sb;

    logic signed [CALC_W-1:0]  r_x_end, r_x_last, r_y_end, r_y_last;
    logic                      r_rect_en, r_circ_en, r_zero_r;
    logic [SQ_W-1:0]           r_lo, r_hi;

    logic [X_W-1:0]            r_x;
    logic [Y_W-1:0]            r_y;
    logic [ADDR_W-1:0]         r_addr;

    logic                      r_s1_valid;
    logic [ADDR_W-1:0]         r_s1_addr;
    logic                      r_s1_we;
    logic [1:0]                r_s1_shade;
    logic                      r_s1_circle;
    logic [DSQ_W-1:0]          r_s1_dx2, r_s1_dy2;

    logic [1:0]                r_rd_data;
    logic [1:0]                r_shade;
    logic                      r_off;

    // setup arithmetic
    logic signed [2*FIELD_W-1:0] sq;
    logic signed [CALC_W-1:0]    x_end, y_end;

    // per-pixel terms
    logic signed [CALC_W-1:0]    xs, ys, pxs, pys, dx, dy;
    logic signed [2*CALC_W-1:0]  dx_sq, dy_sq;
    logic                        in_x, in_y, inner;
    logic                        n_we, n_circle;
    logic [1:0]                  n_shade;

    // write side
    logic [SQ_W-1:0]             d;
    logic                        c_gray, c_white, wen;
    logic [1:0]                  wdata;

    // read side
    logic [ADDR_W-1:0]           rd_addr;
    logic                        off;

    assign sq    = r_sa * r_sa;
    assign x_end = CALC_W'(r_px) + CALC_W'(r_sa);
    assign y_end = CALC_W'(r_py) + CALC_W'(r_sb);

    assign xs  = $signed(CALC_W'(r_x));
    assign ys  = $signed(CALC_W'(r_y));
    assign pxs = CALC_W'(r_px);
    assign pys = CALC_W'(r_py);
    assign dx  = xs - pxs;
    assign dy  = ys - pys;
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    assign in_x  = (xs >= pxs) && (xs < r_x_end);
    assign in_y  = (ys >= pys) && (ys < r_y_end);
    assign inner = (xs > pxs) && (xs < r_x_last) && (ys > pys) && (ys < r_y_last);

    always_comb begin
        n_we     = 1'b0;
        n_circle = 1'b0;
        n_shade  = SHADE_BLACK;
        unique case (r_cmd)
            CMD_CLEAR: begin
                n_we = 1'b1;
            end
            CMD_RECT: begin
                n_we    = r_rect_en && in_x && in_y;
                n_shade = inner ? SHADE_GRAY : SHADE_WHITE;
            end
            CMD_CIRCLE: begin
                n_circle = r_circ_en;
            end
            default: begin
            end
        endcase
    end

    // squared distance vs. r*r-r and r*r+r; radius zero marks the centre only
    assign d       = SQ_W'(r_s1_dx2) + SQ_W'(r_s1_dy2);
    assign c_gray  = !r_zero_r && (d <= r_lo);
    assign c_white = r_zero_r ? (d == '0) : (d <= r_hi);
    assign wen     = r_s1_valid && (r_s1_we || (r_s1_circle && (c_gray || c_white)));
    assign wdata   = r_s1_circle ? (c_gray ? SHADE_GRAY : SHADE_WHITE) : r_s1_shade;

    assign rd_addr = ADDR_W'(32'(r_py[Y_W-1:0]) * CANVAS_COLS + 32'(r_px[X_W-1:0]));
    assign off     = r_px[FIELD_W-1] || r_py[FIELD_W-1]
                  || ($signed(CALC_W'(r_px)) >= $signed(CALC_W'(CANVAS_COLS)))
                  || ($signed(CALC_W'(r_py)) >= $signed(CALC_W'(CANVAS_ROWS)));

    assign o_stat.last_pixel = (r_x == X_W'(CANVAS_COLS - 1)) && (r_y == Y_W'(CANVAS_ROWS - 1));
    assign o_stat.pipe_busy  = r_s1_valid;
    assign o_shade      = r_shade;
    assign o_off_canvas = r_off;

    // control state: sweep position, pipe valid, command kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= CMD_CLEAR;
            r_x        <= '0;
            r_y        <= '0;
            r_addr     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_dp.step;
            if (i_dp.load) begin
                r_cmd  <= t_cmd'(i_command);
                r_x    <= '0;
                r_y    <= '0;
                r_addr <= '0;
            end else if (i_dp.step) begin
                r_addr <= r_addr + 1'b1;
                if (r_x == X_W'(CANVAS_COLS - 1)) begin
                    r_x <= '0;
                    r_y <= r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_dp.load) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_sa    <= i_size_a;
            r_sb    <= i_size_b;
            r_shade <= SHADE_BLACK;
            r_off   <= 1'b0;
        end
        if (i_dp.setup) begin
            r_x_end   <= x_end;
            r_x_last  <= x_end - 1'b1;
            r_y_end   <= y_end;
            r_y_last  <= y_end - 1'b1;
            r_rect_en <= !r_sa[FIELD_W-1] && (r_sa != '0) && !r_sb[FIELD_W-1] && (r_sb != '0);
            r_circ_en <= !r_sa[FIELD_W-1];
            r_zero_r  <= (r_sa == '0);
            r_lo      <= SQ_W'(sq) - SQ_W'(r_sa);
            r_hi      <= SQ_W'(sq) + SQ_W'(r_sa);
        end
        r_s1_addr   <= r_addr;
        r_s1_we     <= n_we;
        r_s1_shade  <= n_shade;
        r_s1_circle <= n_circle;
        r_s1_dx2    <= dx_sq[DSQ_W-1:0];
        r_s1_dy2    <= dy_sq[DSQ_W-1:0];
        if (i_dp.rd_capture) begin
            r_shade <= off ? SHADE_BLACK : r_rd_data;
            r_off   <= off;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[r_s1_addr] <= wdata;
        end
        if (i_dp.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

[design/csr_ctrl.sv]
// Controller: sequences clearing pass, draw sweeps and pixel reads.
module csr_ctrl
    import csr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_dp,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_dp    = '0;
        unique case (r_state)
            S_INIT: begin
                o_dp.step = 1'b1;
                if (i_stat.last_pixel) n_state = S_INIT_DRAIN;
            end
            S_INIT_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_dp.load = 1'b1;
                    n_state   = (t_cmd'(i_command) == CMD_READ) ? S_READ : S_SETUP;
                end
            end
            S_SETUP: begin
                o_dp.setup = 1'b1;
                n_state    = S_SWEEP;
            end
            S_SWEEP: begin
                o_dp.step = 1'b1;
                if (i_stat.last_pixel) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_DONE;
            end
            S_READ: begin
                o_dp.rd_issue = 1'b1;
                n_state       = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_dp.rd_capture = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

[design/csr_checker.sv]
// Port-level checks for the canvas shape rasterizer, bound to the top level.
module csr_checker
    import csr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_shade,
    input logic       o_off_canvas
);

    // a result is only given while a command is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // one result per command, then idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result");

    // a transfer starts work at once
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start work");

    // quiet result ports between strobes
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_shade == SHADE_BLACK && !o_off_canvas))
        else $error("result ports active without strobe");

    // off-canvas reads give black, and no shade code beyond white
    a_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_shade == SHADE_BLACK || o_shade == SHADE_GRAY
                     || o_shade == SHADE_WHITE)
                    && (!o_off_canvas || o_shade == SHADE_BLACK)))
        else $error("bad shade on result");

endmodule

bind canvas_shape_rasterizer_unit csr_checker u_csr_checker (.*);
